// ----- hdl/foc_pkg.sv -----
// Shared types and constants for the FOC current loop.
package foc_pkg;

  localparam int DW = 16;        // current/voltage data width
  localparam int TW = 16;        // trig width
  localparam int ACCW = 48;      // accumulator width
  localparam int IW = 27;        // integrator width

  localparam logic [2:0] REG_ID_REF = 3'd0;
  localparam logic [2:0] REG_IQ_REF = 3'd1;
  localparam logic [2:0] REG_KP     = 3'd2;
  localparam logic [2:0] REG_KI     = 3'd3;
  localparam logic [2:0] REG_LIMIT  = 3'd4;

  localparam logic signed [17:0] K_TWO_THIRDS_HALF = 18'sd21845;
  localparam logic signed [17:0] K_INV_SQRT3       = 18'sd37837;
  localparam logic signed [17:0] K_SQRT3_HALF      = 18'sd56756;
  localparam logic signed [17:0] K_NEG_HALF        = -18'sd32768;

  // Datapath command: operand selects and accumulator action.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_ALPHA,     // acc = (2a-b-c)*k
    OP_RND16_A,   // alpha = rnd16(acc)
    OP_BETA,      // acc = (b-c)*k
    OP_RND16_B,   // beta = rnd16(acc)
    OP_ID0, OP_ID1, OP_ID_END,
    OP_IQ0, OP_IQ1, OP_IQ_END,
    OP_KI_D, OP_INT_D, OP_KP_D, OP_VD_END,
    OP_KI_Q, OP_INT_Q, OP_KP_Q, OP_VQ_END,
    OP_VAL0, OP_VAL1, OP_VAL_END,
    OP_VBE0, OP_VBE1, OP_VBE_END,
    OP_VB0, OP_VB1, OP_VB_END,
    OP_VC0, OP_VC1, OP_VC_END
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   load;      // capture input beat
    logic   out_load;  // move results to output register
  } dp_cmd_t;

  function automatic logic signed [DW-1:0] sat_dw(input logic signed [ACCW-1:0] x);
    logic signed [ACCW-1:0] hi;
    logic signed [ACCW-1:0] lo;
    hi = ACCW'((64'sd1 <<< (DW - 1)) - 1);
    lo = -hi - ACCW'(1);
    if (x > hi) return DW'(hi);
    if (x < lo) return DW'(lo);
    return DW'(x);
  endfunction

  function automatic logic signed [ACCW-1:0] rnd_sh(input logic signed [ACCW-1:0] x,
                                                   input int n);
    logic signed [ACCW-1:0] y;
    y = x + (ACCW'(1) <<< (n - 1));
    return y >>> n;
  endfunction

endpackage

// ----- hdl/foc_current_loop.sv -----
// Top level of the FOC current loop.
// Input beat on s_axis: i_a, i_b, i_c, sin_theta, cos_theta.
// Output beat on m_axis: v_a, v_b, v_c, i_d, i_q, v_d, v_q.
// Registers (id_ref, iq_ref, kp_gain, ki_gain, integral_limit) are written
// through cfg_we_i/cfg_addr_i/cfg_data_i. The user must write them only while
// the block is idle; the block itself does not enforce this.
// A single shared multiplier runs the Clarke, Park, PI and inverse transforms
// in 30 steps. A new beat is accepted in the cycle after the result moves to
// the output register; no beat is taken while an item is in work.
// The output register holds a finished result while the sink stalls; the
// next item may then run, and waits before its own output step until the
// register is free.
// Reset clears the integrators, loads the register defaults, and empties
// the output register.
module foc_current_loop (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [79:0]  s_axis_tdata,  // i_a, i_b, i_c, sin_theta, cos_theta
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [111:0] m_axis_tdata,  // v_a, v_b, v_c, i_d, i_q, v_d, v_q
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_addr_i,
  input  logic [23:0]  cfg_data_i
);
  import foc_pkg::*;

  dp_cmd_t cmd;
  logic signed [15:0] id_ref_q, iq_ref_q;
  logic [23:0] kp_q, ki_q;
  logic [14:0] lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_ref_q <= 16'sd0;
      iq_ref_q <= 16'sd1536;
      kp_q     <= 24'd104858;
      ki_q     <= 24'd1049;
      lim_q    <= 15'd10240;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_ID_REF: id_ref_q <= cfg_data_i[15:0];
        REG_IQ_REF: iq_ref_q <= cfg_data_i[15:0];
        REG_KP:     kp_q     <= cfg_data_i;
        REG_KI:     ki_q     <= cfg_data_i;
        REG_LIMIT:  lim_q    <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  foc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .cmd_o      (cmd)
  );

  foc_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i     (cmd),
    .in_data_i (s_axis_tdata),
    .id_ref_i  (id_ref_q),
    .iq_ref_i  (iq_ref_q),
    .kp_i      (kp_q),
    .ki_i      (ki_q),
    .lim_i     (lim_q),
    .out_data_o(m_axis_tdata)
  );

endmodule

// ----- hdl/foc_datapath.sv -----
// Datapath of the FOC current loop: one shared multiplier and an accumulator.
module foc_datapath (
  input  logic                          clk_i,
  input  foc_pkg::dp_cmd_t              cmd_i,
  input  logic [5*foc_pkg::DW-1:0]      in_data_i,
  input  logic signed [15:0]            id_ref_i,
  input  logic signed [15:0]            iq_ref_i,
  input  logic [23:0]                   kp_i,
  input  logic [23:0]                   ki_i,
  input  logic [14:0]                   lim_i,
  input  logic                          rst_ni,
  output logic [7*foc_pkg::DW-1:0]      out_data_o
);
  import foc_pkg::*;

  logic signed [DW-1:0] ia_q, ib_q, ic_q, sn_q, cs_q;
  logic signed [ACCW-1:0] acc_q, acc_d;
  logic signed [DW:0] al_q, be_q;         // alpha/beta need one bit more
  logic signed [DW-1:0] id_q, iq_q, vd_q, vq_q, va_q, vb_q, vc_q;
  logic signed [ACCW-1:0] vaf_q, vbf_q;   // unsaturated valpha/vbeta
  logic signed [DW:0] err_q;
  logic signed [IW-1:0] intd_q, intq_q;
  logic signed [ACCW-1:0] pk_q;           // rnd10(err*ki) hold
  logic signed [31:0] ma;
  logic signed [24:0] mb;
  logic signed [56:0] prod_full;
  logic signed [ACCW-1:0] prod;
  logic signed [ACCW-1:0] lim_w, itmp;

  assign lim_w = ACCW'({1'b0, lim_i}) <<< 10;

  // Operand select for the single multiplier.
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.op)
      OP_ALPHA: begin
        ma = 32'(ia_q) * 2 - 32'(ib_q) - 32'(ic_q);
        mb = 25'(K_TWO_THIRDS_HALF);
      end
      OP_BETA:  begin ma = 32'(ib_q) - 32'(ic_q); mb = 25'(K_INV_SQRT3); end
      OP_ID0:   begin ma = 32'(al_q); mb = 25'(cs_q); end
      OP_ID1:   begin ma = 32'(be_q); mb = 25'(sn_q); end
      OP_IQ0:   begin ma = 32'(be_q); mb = 25'(cs_q); end
      OP_IQ1:   begin ma = -32'(al_q); mb = 25'(sn_q); end
      OP_KI_D, OP_KI_Q: begin ma = 32'(err_q); mb = $signed({1'b0, ki_i}); end
      OP_KP_D, OP_KP_Q: begin ma = 32'(err_q); mb = $signed({1'b0, kp_i}); end
      OP_VAL0:  begin ma = 32'(vd_q); mb = 25'(cs_q); end
      OP_VAL1:  begin ma = -32'(vq_q); mb = 25'(sn_q); end
      OP_VBE0:  begin ma = 32'(vd_q); mb = 25'(sn_q); end
      OP_VBE1:  begin ma = 32'(vq_q); mb = 25'(cs_q); end
      OP_VB0, OP_VC0: begin ma = 32'(vaf_q); mb = 25'(K_NEG_HALF); end
      OP_VB1:   begin ma = 32'(vbf_q); mb = 25'(K_SQRT3_HALF); end
      OP_VC1:   begin ma = -32'(vbf_q); mb = 25'(K_SQRT3_HALF); end
      default: ;
    endcase
  end

  assign prod_full = ma * mb;
  assign prod = ACCW'(prod_full);

  always_comb begin
    acc_d = acc_q;
    case (cmd_i.op)
      OP_ALPHA, OP_BETA, OP_ID0, OP_IQ0, OP_VAL0, OP_VBE0, OP_VB0, OP_VC0,
      OP_KI_D, OP_KI_Q, OP_KP_D, OP_KP_Q: acc_d = prod;
      OP_ID1, OP_IQ1, OP_VAL1, OP_VBE1, OP_VB1, OP_VC1: acc_d = acc_q + prod;
      default: ;
    endcase
  end

  always_comb begin
    itmp = '0;
    if (cmd_i.op == OP_INT_D) itmp = ACCW'(intd_q) + pk_q;
    else itmp = ACCW'(intq_q) + pk_q;
    if (itmp > lim_w) itmp = lim_w;
    else if (itmp < -lim_w) itmp = -lim_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      intd_q <= '0;
      intq_q <= '0;
    end else if (cmd_i.op == OP_INT_D) begin
      intd_q <= IW'(itmp);
    end else if (cmd_i.op == OP_INT_Q) begin
      intq_q <= IW'(itmp);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (cmd_i.load) begin
      ia_q <= in_data_i[0*DW +: DW];
      ib_q <= in_data_i[1*DW +: DW];
      ic_q <= in_data_i[2*DW +: DW];
      sn_q <= in_data_i[3*DW +: DW];
      cs_q <= in_data_i[4*DW +: DW];
    end
    case (cmd_i.op)
      OP_RND16_A: al_q <= (DW+1)'(rnd_sh(acc_q, 16));
      OP_RND16_B: be_q <= (DW+1)'(rnd_sh(acc_q, 16));
      OP_ID_END: begin
        id_q  <= sat_dw(rnd_sh(acc_q, 14));
        err_q <= (DW+1)'(id_ref_i) - (DW+1)'(sat_dw(rnd_sh(acc_q, 14)));
      end
      OP_IQ_END: begin
        iq_q  <= sat_dw(rnd_sh(acc_q, 14));
      end
      OP_INT_D, OP_INT_Q: ;
      OP_VD_END: begin
        vd_q  <= sat_dw(rnd_sh(acc_q, 20) + rnd_sh(ACCW'(intd_q), 10));
        err_q <= (DW+1)'(iq_ref_i) - (DW+1)'(iq_q);
      end
      OP_VQ_END: vq_q <= sat_dw(rnd_sh(acc_q, 20) + rnd_sh(ACCW'(intq_q), 10));
      OP_VAL_END: begin
        vaf_q <= rnd_sh(acc_q, 14);
        va_q  <= sat_dw(rnd_sh(acc_q, 14));
      end
      OP_VBE_END: vbf_q <= rnd_sh(acc_q, 14);
      OP_VB_END: vb_q <= sat_dw(rnd_sh(acc_q, 16));
      OP_VC_END: vc_q <= sat_dw(rnd_sh(acc_q, 16));
      default: ;
    endcase
    if (cmd_i.op == OP_KI_D || cmd_i.op == OP_KI_Q) pk_q <= rnd_sh(prod, 10);
    if (cmd_i.out_load)
      out_data_o <= {vq_q, vd_q, iq_q, id_q, vc_q, vb_q, va_q};
  end

endmodule

// ----- hdl/foc_ctrl.sv -----
// Sequencer of the FOC current loop: steps the datapath through one item.
module foc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output foc_pkg::dp_cmd_t cmd_o
);
  import foc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;
  dp_op_e op_q, op_d;
  logic   ov_q, ov_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = ov_q;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    ov_d    = ov_q;
    cmd_o.op       = OP_NONE;
    cmd_o.load     = 1'b0;
    cmd_o.out_load = 1'b0;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (state_q)
      ST_IDLE: if (in_valid_i) begin
        cmd_o.load = 1'b1;
        op_d = OP_ALPHA;
        state_d = ST_RUN;
      end
      ST_RUN: begin
        cmd_o.op = op_q;
        if (op_q == OP_VC_END) state_d = ST_DONE;
        else op_d = dp_op_e'(op_q + 5'd1);
      end
      ST_DONE: if (!ov_q || out_ready_i) begin
        cmd_o.out_load = 1'b1;
        ov_d = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_NONE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      ov_q    <= ov_d;
    end
  end

endmodule

// ----- hdl/foc_checker.sv -----
// Port-level checker for the FOC current loop, bound to the top level.
module foc_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [111:0] m_axis_tdata
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat dropped or changed under stall");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in work");

  a_no_instant_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result appeared too early");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid || rst_ni)
    else $error("output valid out of reset");
endmodule

bind foc_current_loop foc_checker u_chk (.*);
